@@ rtl/core/crpm_pkg.sv @@
// Package for the capture-period tachometer.
// Holds field widths, register indexes, item codes, sequencer states and the
// divider status type shared by crpm_div and capture_period_rpm_meter.
package crpm_pkg;

	localparam int TS_W      = 32;	// capture timestamp
	localparam int BLADE_W   = 3;	// blade_count register
	localparam int TMO_W     = 16;	// timeout_ticks register
	localparam int LOST_W    = 16;	// lost tick counter
	localparam int RPM_W     = 30;	// rpm result
	localparam int SHOWN_W   = 16;	// low rpm bits compared for rpm_changed
	localparam int CFG_A_W   = 1;
	localparam int CFG_D_W   = 16;
	localparam int DEN_W     = TS_W + BLADE_W;

	localparam logic [BLADE_W-1:0] BLADE_RESET   = 3'd1;
	localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd100;

	// configuration register indexes
	localparam logic [CFG_A_W-1:0] REG_BLADE_COUNT   = 1'b0;
	localparam logic [CFG_A_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

	// input item kinds
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/capture_period_rpm_meter.sv @@
// Capture-period tachometer: rpm = 60*TIMER_HZ / (delta*blade_count).
// A capture beat is taken only while idle and gives no result. A tick beat gives its
// result once the one-bit-per-cycle divider has shifted through the NUM_W dividend
// bits; with delta*blades zero the divider is skipped. No beat is taken until the tick
// is done and its result is in the output register, so captures come one per cycle only
// while idle. Reset: arst_n clears all state but den_q and the output data bits;
// blade_count returns to 1, timeout_ticks to 100.
module capture_period_rpm_meter import crpm_pkg::*; #(
	parameter int TIMER_HZ = 10000000
) (
	input  logic               clk,
	input  logic               arst_n,
	// input stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,	// [31:0] timestamp
	input  logic [0:0]         s_tuser,	// [0] operation
	// result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,	// [29:0] rpm, [31:30] zero
	output logic [0:0]         m_tuser,	// [0] rpm_changed
	// configuration write port
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_D_W-1:0] cfg_wdata
);

	// dividend is the constant 60*TIMER_HZ; its width sets the divider length
	localparam logic [63:0] RPM_NUM = 64'd60 * 64'(TIMER_HZ);
	localparam int NUM_W = $clog2(RPM_NUM + 64'd1);
	localparam int EXT_W = (NUM_W > RPM_W) ? NUM_W : RPM_W + 1;

	// configuration
	logic [BLADE_W-1:0] blade_q;
	logic [TMO_W-1:0]   timeout_q;

	// capture and tracking state
	logic [TS_W-1:0]    latest_q;
	logic [TS_W-1:0]    previous_q;
	logic               seen_q;
	logic [LOST_W-1:0]  lost_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [SHOWN_W-1:0] shown_q;

	// per-tick work registers
	logic [DEN_W-1:0]   den_q;
	logic               div_en_q;	// delta*blades nonzero: divide
	logic               zero_q;	// signal lost: force rpm to zero

	// output register
	logic               m_tvalid_q;
	logic [RPM_W-1:0]   m_rpm_q;
	logic               m_chg_q;

	state_t             state_q, state_d;
	logic               div_start;
	logic               take_out;
	logic               acc;
	div_stat_t          div_stat;
	logic [NUM_W-1:0]   quot;

	logic [TS_W-1:0]    delta;
	logic [DEN_W-1:0]   den;
	logic [LOST_W-1:0]  lost_inc;
	logic [EXT_W-1:0]   q_ext;
	logic [RPM_W-1:0]   q_sat;
	logic [RPM_W-1:0]   rpm_new;

	// sequencer: next state and strobes
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		take_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser[0] == OP_TICK) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				// skip the divider when delta*blades is zero
				div_start = div_en_q;
				state_d   = div_en_q ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					take_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign acc = s_tvalid && s_tready;

	// period and denominator straight from the stored captures
	always_comb begin
		delta    = latest_q - previous_q;
		den      = DEN_W'(delta) * DEN_W'(blade_q);
		lost_inc = (lost_q != {LOST_W{1'b1}}) ? lost_q + 1'b1 : lost_q;
		q_ext    = EXT_W'(quot);
		q_sat    = (|q_ext[EXT_W-1:RPM_W]) ? {RPM_W{1'b1}} : q_ext[RPM_W-1:0];
		if (zero_q) begin
			rpm_new = '0;
		end else if (div_en_q) begin
			rpm_new = q_sat;
		end else begin
			rpm_new = rpm_q;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blade_q   <= BLADE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLADE_COUNT:   blade_q   <= cfg_wdata[BLADE_W-1:0];
				REG_TIMEOUT_TICKS: timeout_q <= cfg_wdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	// tracking state: captures shift in, ticks update the lost counter at once
	// and rpm when the result is handed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q   <= '0;
			previous_q <= '0;
			seen_q     <= 1'b0;
			lost_q     <= '0;
			rpm_q      <= '0;
			shown_q    <= '0;
			div_en_q   <= 1'b0;
			zero_q     <= 1'b0;
		end else begin
			if (acc && s_tuser[0] == OP_CAPTURE) begin
				previous_q <= latest_q;
				latest_q   <= s_tdata[TS_W-1:0];
				seen_q     <= 1'b1;
			end
			if (acc && s_tuser[0] == OP_TICK) begin
				div_en_q <= (den != '0);
				if (!seen_q) begin
					lost_q <= lost_inc;
					zero_q <= lost_inc > timeout_q;
				end else begin
					lost_q <= '0;
					seen_q <= 1'b0;
					zero_q <= 1'b0;
				end
			end
			if (take_out) begin
				rpm_q   <= rpm_new;
				shown_q <= rpm_new[SHOWN_W-1:0];
			end
		end
	end

	// denominator, held for the divider load
	always_ff @(posedge clk) begin
		if (acc && s_tuser[0] == OP_TICK) begin
			den_q <= den;
		end
	end

	crpm_div #(
		.NUM_W (NUM_W),
		.D_W   (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (RPM_NUM[NUM_W-1:0]),
		.den    (den_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	// output register: load on completion, drop on handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (take_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_out) begin
			m_rpm_q <= rpm_new;
			m_chg_q <= rpm_new[SHOWN_W-1:0] != shown_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {{(32 - RPM_W){1'b0}}, m_rpm_q};
	assign m_tuser[0] = m_chg_q;

endmodule

@@ rtl/core/crpm_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on crpm_pkg for the status type.
module crpm_div import crpm_pkg::*; #(
	parameter int NUM_W = 33,
	parameter int D_W   = 35
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [D_W-1:0]   den,
	output div_stat_t        stat,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [D_W-1:0]   den_q;
	logic [D_W-1:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [D_W:0]     trial;
	logic             ge;
	logic [D_W:0]     diff;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// control: count the steps and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift the dividend out, the quotient in
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule
